// File: hw/rtl/timer_queue_set_cancel_expire_defines.svh
// Assertion macros used by the timer queue RTL.
`ifndef TIMER_QUEUE_SET_CANCEL_EXPIRE_DEFINES_SVH
`define TIMER_QUEUE_SET_CANCEL_EXPIRE_DEFINES_SVH

`ifndef SYNTHESIS

// A condition that must hold at every clock edge out of reset.
`define TQSCE_ASSERT_HOLDS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("timer queue assertion failed");

// A condition that must hold in the same cycle as its trigger.
`define TQSCE_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("timer queue assertion failed");

// A condition that must hold in the cycle after its trigger.
`define TQSCE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("timer queue assertion failed");

`else

`define TQSCE_ASSERT_HOLDS(label, clk, rst, cond)
`define TQSCE_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define TQSCE_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: hw/rtl/tqsce_pkg.sv
`timescale 1ns / 1ps

package tqsce_pkg;

   // Default sizing of the queue.
   localparam int SLOTS_DEF   = 16;
   localparam int ID_BITS_DEF = 16;

   // Width of the id and delay fields on the ports.
   localparam int FIELD_BITS = 16;

   // Command codes of an input transaction.
   typedef enum logic [1:0] {
      CMD_SET    = 2'd0,
      CMD_CANCEL = 2'd1,
      CMD_TICK   = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   // Result kinds.
   typedef enum logic [2:0] {
      KIND_SET_OK     = 3'd0,
      KIND_EXPIRED    = 3'd1,
      KIND_CANCELLED  = 3'd2,
      KIND_NOT_FOUND  = 3'd3,
      KIND_QUEUE_FULL = 3'd4
   } kind_type;

   // Control part of the wave that travels down the row of cells.
   // For a tick the wave is a scan and hit means a due timer was found.
   typedef struct packed {
      logic    active;
      cmd_type op;
      logic    hit;
   } wave_ctl_type;

endpackage

// File: hw/rtl/tqsce_cell.sv
`timescale 1ns / 1ps

module tqsce_cell #(
   parameter int ID_BITS    = tqsce_pkg::ID_BITS_DEF,
   parameter int CMP_BITS   = tqsce_pkg::FIELD_BITS,
   parameter int SLOT_BITS  = $clog2(tqsce_pkg::SLOTS_DEF),
   parameter int CNT_BITS   = $clog2(tqsce_pkg::SLOTS_DEF + 1),
   parameter int CELL_INDEX = 0
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                tick,
   input  logic                                clr_en,
   input  logic [SLOT_BITS-1:0]                clr_slot,
   input  tqsce_pkg::wave_ctl_type             in_ctl,
   input  logic [CMP_BITS-1:0]                 in_id,
   input  logic [tqsce_pkg::FIELD_BITS-1:0]    in_delay,
   input  logic [CNT_BITS-1:0]                 in_count,
   input  logic [SLOT_BITS-1:0]                in_slot,
   output tqsce_pkg::wave_ctl_type             out_ctl,
   output logic [CMP_BITS-1:0]                 out_id,
   output logic [tqsce_pkg::FIELD_BITS-1:0]    out_delay,
   output logic [CNT_BITS-1:0]                 out_count,
   output logic [SLOT_BITS-1:0]                out_slot
);
   import tqsce_pkg::*;

   // Timer held in this cell.
   logic                  valid_ff, valid_in;
   logic                  due_ff, due_in;
   logic [ID_BITS-1:0]    id_ff, id_in;
   logic [FIELD_BITS-1:0] rem_ff, rem_in;

   // Wave handed to the next cell.
   wave_ctl_type          ctl_ff, ctl_in;
   logic [CMP_BITS-1:0]   wid_ff, wid_in;
   logic [FIELD_BITS-1:0] wdelay_ff, wdelay_in;
   logic [CNT_BITS-1:0]   wcount_ff, wcount_in;
   logic [SLOT_BITS-1:0]  wslot_ff, wslot_in;

   logic [CMP_BITS-1:0]   own_id_ext;

   assign own_id_ext = CMP_BITS'(id_ff);

   // Timer update and wave processing.
   always_comb begin
      valid_in  = valid_ff;
      due_in    = due_ff;
      id_in     = id_ff;
      rem_in    = rem_ff;
      ctl_in    = in_ctl;
      wid_in    = in_id;
      wdelay_in = in_delay;
      wcount_in = in_count;
      wslot_in  = in_slot;

      // Count down on a tick; a timer at one or below expires.
      if (tick && valid_ff) begin
         if (rem_ff <= FIELD_BITS'(1)) begin
            valid_in = 1'b0;
            due_in   = 1'b1;
         end else begin
            rem_in = rem_ff - FIELD_BITS'(1);
         end
      end

      // The expired timer just reported leaves the due set.
      if (clr_en && (clr_slot == SLOT_BITS'(CELL_INDEX))) begin
         due_in = 1'b0;
      end

      if (in_ctl.active) begin
         case (in_ctl.op)
            CMD_SET: begin
               // The first free cell along the row takes the timer.
               if (!in_ctl.hit && !valid_ff) begin
                  valid_in   = 1'b1;
                  id_in      = in_id[ID_BITS-1:0];
                  rem_in     = (in_delay == '0) ? FIELD_BITS'(1) : in_delay;
                  ctl_in.hit = 1'b1;
               end
            end
            CMD_CANCEL: begin
               // Every live timer with a matching id is removed.
               if (valid_ff && (own_id_ext == in_id)) begin
                  valid_in   = 1'b0;
                  ctl_in.hit = 1'b1;
               end
            end
            CMD_TICK: begin
               // Scan: count due timers and keep the lowest id, earliest cell on ties.
               if (due_ff) begin
                  wcount_in = in_count + CNT_BITS'(1);
                  if (!in_ctl.hit || (id_ff < in_id[ID_BITS-1:0])) begin
                     ctl_in.hit = 1'b1;
                     wid_in     = own_id_ext;
                     wslot_in   = SLOT_BITS'(CELL_INDEX);
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         due_ff   <= 1'b0;
         ctl_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         due_ff   <= due_in;
         ctl_ff   <= ctl_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      id_ff     <= id_in;
      rem_ff    <= rem_in;
      wid_ff    <= wid_in;
      wdelay_ff <= wdelay_in;
      wcount_ff <= wcount_in;
      wslot_ff  <= wslot_in;
   end

   assign out_ctl   = ctl_ff;
   assign out_id    = wid_ff;
   assign out_delay = wdelay_ff;
   assign out_count = wcount_ff;
   assign out_slot  = wslot_ff;

endmodule

// File: hw/rtl/timer_queue_set_cancel_expire.sv
`timescale 1ns / 1ps
`include "timer_queue_set_cancel_expire_defines.svh"

// Queue of up to SLOTS one-shot timers driven by commands.
// A command transaction is taken when start is high and busy is low:
// req_cmd selects set (req_delay_ticks), cancel (req_timer_id) or tick.
// Results leave on rsp_valid for one cycle each with rsp_kind,
// rsp_timer_id_res and rsp_last; the receiver cannot stall them.
// Each command sends one wave down a row of SLOTS cells, one cell per
// cycle. Set and cancel give their single result once the wave leaves
// the last cell, and busy drops in that same cycle.
// A tick counts all timers down at once, then runs one wave per expired
// timer, each finding the lowest due id and giving one result; a tick
// with nothing due gives no result.
// The unused command code is taken and dropped without a result.
// Reset empties the queue and zeroes the id counter.
module timer_queue_set_cancel_expire #(
   parameter int SLOTS   = tqsce_pkg::SLOTS_DEF,
   parameter int ID_BITS = tqsce_pkg::ID_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_cmd,
   input  logic [tqsce_pkg::FIELD_BITS-1:0]  req_delay_ticks,
   input  logic [tqsce_pkg::FIELD_BITS-1:0]  req_timer_id,
   output logic                              rsp_valid,
   output logic [2:0]                        rsp_kind,
   output logic [tqsce_pkg::FIELD_BITS-1:0]  rsp_timer_id_res,
   output logic                              rsp_last
);
   import tqsce_pkg::*;

   localparam int CMP_BITS  = (ID_BITS > FIELD_BITS) ? ID_BITS : FIELD_BITS;
   localparam int SLOT_BITS = $clog2(SLOTS);
   localparam int CNT_BITS  = $clog2(SLOTS + 1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   state_type             state_ff, state_in;
   logic [ID_BITS-1:0]    next_id_ff, next_id_in;
   wave_ctl_type          inj_ctl_ff, inj_ctl_in;
   logic [CMP_BITS-1:0]   inj_id_ff, inj_id_in;
   logic [FIELD_BITS-1:0] inj_delay_ff, inj_delay_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   kind_type              rsp_kind_ff, rsp_kind_in;
   logic [FIELD_BITS-1:0] rsp_id_ff, rsp_id_in;
   logic                  rsp_last_ff, rsp_last_in;

   // Links of the cell row; link 0 is the head register.
   wave_ctl_type          link_ctl   [SLOTS+1];
   logic [CMP_BITS-1:0]   link_id    [SLOTS+1];
   logic [FIELD_BITS-1:0] link_delay [SLOTS+1];
   logic [CNT_BITS-1:0]   link_count [SLOTS+1];
   logic [SLOT_BITS-1:0]  link_slot  [SLOTS+1];
   logic [SLOTS:0]        act_vec;

   logic                  accept;
   logic                  tick;
   logic                  clr_en;
   wave_ctl_type          tail_ctl;

   assign accept = start && (state_ff == ST_IDLE);
   assign tick   = accept && (cmd_type'(req_cmd) == CMD_TICK);

   assign link_ctl[0]   = inj_ctl_ff;
   assign link_id[0]    = inj_id_ff;
   assign link_delay[0] = inj_delay_ff;
   assign link_count[0] = '0;
   assign link_slot[0]  = '0;

   assign tail_ctl = link_ctl[SLOTS];
   assign clr_en   = tail_ctl.active && (tail_ctl.op == CMD_TICK) && tail_ctl.hit;

   // Row of cells, each holding one timer.
   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      tqsce_cell #(
         .ID_BITS    (ID_BITS),
         .CMP_BITS   (CMP_BITS),
         .SLOT_BITS  (SLOT_BITS),
         .CNT_BITS   (CNT_BITS),
         .CELL_INDEX (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .tick      (tick),
         .clr_en    (clr_en),
         .clr_slot  (link_slot[SLOTS]),
         .in_ctl    (link_ctl[g]),
         .in_id     (link_id[g]),
         .in_delay  (link_delay[g]),
         .in_count  (link_count[g]),
         .in_slot   (link_slot[g]),
         .out_ctl   (link_ctl[g+1]),
         .out_id    (link_id[g+1]),
         .out_delay (link_delay[g+1]),
         .out_count (link_count[g+1]),
         .out_slot  (link_slot[g+1])
      );
   end

   for (genvar g = 0; g <= SLOTS; g++) begin : g_act
      assign act_vec[g] = link_ctl[g].active;
   end

   // Command sequencing: launch a wave, then finish it at the tail.
   always_comb begin
      state_in     = state_ff;
      next_id_in   = next_id_ff;
      inj_ctl_in   = '0;
      inj_id_in    = inj_id_ff;
      inj_delay_in = inj_delay_ff;
      rsp_valid_in = 1'b0;
      rsp_kind_in  = rsp_kind_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start && (cmd_type'(req_cmd) != CMD_NONE)) begin
               inj_ctl_in.active = 1'b1;
               inj_ctl_in.op     = cmd_type'(req_cmd);
               inj_ctl_in.hit    = 1'b0;
               inj_id_in         = (cmd_type'(req_cmd) == CMD_SET) ?
                                   CMP_BITS'(next_id_ff) : CMP_BITS'(req_timer_id);
               inj_delay_in      = req_delay_ticks;
               state_in          = ST_RUN;
            end
         end
         ST_RUN: begin
            if (tail_ctl.active) begin
               state_in = ST_IDLE;
               case (tail_ctl.op)
                  CMD_SET: begin
                     rsp_valid_in = 1'b1;
                     rsp_last_in  = 1'b1;
                     if (tail_ctl.hit) begin
                        rsp_kind_in = KIND_SET_OK;
                        rsp_id_in   = link_id[SLOTS][FIELD_BITS-1:0];
                        next_id_in  = next_id_ff + ID_BITS'(1);
                     end else begin
                        rsp_kind_in = KIND_QUEUE_FULL;
                        rsp_id_in   = '0;
                     end
                  end
                  CMD_CANCEL: begin
                     rsp_valid_in = 1'b1;
                     rsp_last_in  = 1'b1;
                     rsp_kind_in  = tail_ctl.hit ? KIND_CANCELLED : KIND_NOT_FOUND;
                     rsp_id_in    = link_id[SLOTS][FIELD_BITS-1:0];
                  end
                  CMD_TICK: begin
                     // Report the lowest due id; scan again while more remain.
                     if (tail_ctl.hit) begin
                        rsp_valid_in = 1'b1;
                        rsp_kind_in  = KIND_EXPIRED;
                        rsp_id_in    = link_id[SLOTS][FIELD_BITS-1:0];
                        rsp_last_in  = (link_count[SLOTS] == CNT_BITS'(1));
                        if (link_count[SLOTS] != CNT_BITS'(1)) begin
                           inj_ctl_in.active = 1'b1;
                           inj_ctl_in.op     = CMD_TICK;
                           inj_ctl_in.hit    = 1'b0;
                           state_in          = ST_RUN;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         next_id_ff   <= '0;
         inj_ctl_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         next_id_ff   <= next_id_in;
         inj_ctl_ff   <= inj_ctl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      inj_id_ff    <= inj_id_in;
      inj_delay_ff <= inj_delay_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_timer_id_res = rsp_id_ff;
   assign rsp_last         = rsp_last_ff;

   // Checks on the sequencing.
   `TQSCE_ASSERT_NEXT(a_cmd_sets_busy, clock, reset, start && !busy && (req_cmd != CMD_NONE), busy)
   `TQSCE_ASSERT_IMPLIES(a_more_keeps_busy, clock, reset, rsp_valid && !rsp_last, busy)
   `TQSCE_ASSERT_IMPLIES(a_single_is_last, clock, reset, rsp_valid && (rsp_kind != KIND_EXPIRED), rsp_last)
   `TQSCE_ASSERT_HOLDS(a_one_wave, clock, reset, $onehot0(act_vec))

endmodule
